/* src/ptlv_pkg.sv */
// ----------------------------------------------------------------------------
// ptlv_pkg
// Shared types and constants for the physical point to linear voxel index block.
// ----------------------------------------------------------------------------
package ptlv_pkg;

    localparam int COORD_W         = 32;
    localparam int VSIZE_W         = 31;
    localparam int IDX_W           = 32;
    localparam int LIN_W           = 64;
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_IDX_W       = 3;
    localparam int DIM_BITS_DEF    = 16;
    localparam int COORD_FRAC_BITS = 12;

    // numerator 2|num| + v and its quotient
    localparam int DIV_W = COORD_W + 2;
    // remainder, below the divisor 2v
    localparam int REM_W = VSIZE_W + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X     = 3'd0,
        CFG_ORIGIN_Y     = 3'd1,
        CFG_ORIGIN_Z     = 3'd2,
        CFG_VSIZE_X      = 3'd3,
        CFG_VSIZE_Y      = 3'd4,
        CFG_VSIZE_Z      = 3'd5,
        CFG_DIMS         = 3'd6,
        CFG_CLAMP_ENABLE = 3'd7
    } t_cfg_reg;

    typedef struct packed {
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [COORD_W-1:0] coord_z;
    } t_in_req;

    typedef struct packed {
        logic signed [IDX_W-1:0] voxel_i;
        logic signed [IDX_W-1:0] voxel_j;
        logic signed [IDX_W-1:0] voxel_k;
        logic signed [LIN_W-1:0] linear_index;
        logic                    out_of_range;
    } t_out_req;

    typedef struct packed {
        logic signed [IDX_W-1:0] idx;
        logic                    oor;
    } t_axis_res;

endpackage

/* src/ptlv_axis.sv */
// ----------------------------------------------------------------------------
// ptlv_axis
// One axis: offset, pipelined restoring divide, rounding, range test and clamp.
// ----------------------------------------------------------------------------
module ptlv_axis #(
    parameter int DIM_BITS = ptlv_pkg::DIM_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic signed [ptlv_pkg::COORD_W-1:0]  i_coord,
    input  logic signed [ptlv_pkg::COORD_W-1:0]  i_origin,
    input  logic        [ptlv_pkg::VSIZE_W-1:0]  i_vsize,
    input  logic        [DIM_BITS-1:0]           i_dim,
    input  logic                                 i_clamp,
    output ptlv_pkg::t_axis_res                  o_res
);

    localparam int DW = ptlv_pkg::DIV_W;
    localparam int RW = ptlv_pkg::REM_W;
    localparam int VW = ptlv_pkg::VSIZE_W;
    localparam int IW = ptlv_pkg::IDX_W;

    logic [VW-1:0]        vv;
    logic signed [DW-1:0] r_num;
    logic [VW-1:0]        r_v0;

    logic [DW-1:0] r_n   [DW+1];
    logic [RW-1:0] r_rem [DW+1];
    logic [DW-1:0] r_q   [DW+1];
    logic [RW-1:0] r_d   [DW+1];
    logic          r_neg [DW+1];

    logic [DW-2:0] abs_num;
    logic [DW-1:0] q;
    logic          lt1;
    logic          gt;
    logic [IW-1:0] n_idx;

    assign vv = (i_vsize == '0) ? VW'(1) : i_vsize;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num <= DW'(i_coord) - DW'(i_origin) + $signed({{(DW-VW){1'b0}}, vv});
            r_v0  <= vv;
        end
    end

    assign abs_num = r_num[DW-1] ? (DW-1)'(-r_num) : r_num[DW-2:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n[0]   <= {abs_num, 1'b0} + DW'(r_v0);
            r_rem[0] <= '0;
            r_q[0]   <= '0;
            r_d[0]   <= {r_v0, 1'b0};
            r_neg[0] <= r_num[DW-1];
        end
    end

    for (genvar k = 0; k < DW; k++) begin : g_div
        logic [RW:0] t;
        logic [RW:0] diff;
        logic        ge;

        assign t    = {r_rem[k], r_n[k][DW-1]};
        assign diff = t - {1'b0, r_d[k]};
        assign ge   = (t >= {1'b0, r_d[k]});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1] <= ge ? diff[RW-1:0] : t[RW-1:0];
                r_n[k+1]   <= {r_n[k][DW-2:0], 1'b0};
                r_q[k+1]   <= {r_q[k][DW-2:0], ge};
                r_d[k+1]   <= r_d[k];
                r_neg[k+1] <= r_neg[k];
            end
        end
    end

    assign q   = r_q[DW];
    assign lt1 = r_neg[DW] || (q == '0);
    assign gt  = !lt1 && (q > DW'(i_dim));

    always_comb begin
        if (i_clamp && (lt1 || gt)) begin
            n_idx = lt1 ? IW'(1) : IW'(i_dim);
        end else if (r_neg[DW]) begin
            n_idx = (q > (DW'(1) << (IW-1))) ? {1'b1, {(IW-1){1'b0}}} : IW'(-q[IW-1:0]);
        end else begin
            n_idx = (q > ((DW'(1) << (IW-1)) - DW'(1))) ? {1'b0, {(IW-1){1'b1}}} : q[IW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_res.idx <= n_idx;
            o_res.oor <= lt1 || gt;
        end
    end

endmodule

/* src/physical_to_linear_voxel_index.sv */
// ----------------------------------------------------------------------------
// physical_to_linear_voxel_index
// Maps a Q19.12 physical point to 1-based voxel indices and a linear index.
// ----------------------------------------------------------------------------
//  channel  | valid       | flow control | payload
//  ---------+-------------+--------------+-------------------------
//  request  | i_in_valid  | o_in_stall   | i_in_data  (t_in_req)
//  result   | o_out_valid | i_out_stall  | o_out_data (t_out_req)
//  config   | i_cfg_valid | o_cfg_ready  | i_cfg_index, i_cfg_data
//
//  One request per cycle unless a held result stalls the pipeline.
//  The pipeline depth is set by the one-bit-per-stage divider on each axis.
//  Reset clears the valid bits and loads the register defaults.
//  A stall on the result side holds the whole pipeline; nothing is dropped.
//  Configuration writes are always taken (o_cfg_ready is tied high).
// ----------------------------------------------------------------------------
module physical_to_linear_voxel_index #(
    parameter int DIM_BITS = ptlv_pkg::DIM_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  ptlv_pkg::t_in_req                    i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output ptlv_pkg::t_out_req                   o_out_data,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [ptlv_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [ptlv_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int IW    = ptlv_pkg::IDX_W;
    localparam int CW    = ptlv_pkg::COORD_W;
    localparam int VW    = ptlv_pkg::VSIZE_W;
    localparam int LW    = ptlv_pkg::LIN_W;
    localparam int LAT_A = ptlv_pkg::DIV_W + 3;
    localparam int NSTG  = LAT_A + 3;
    localparam int PJ_W  = IW + 1 + DIM_BITS + 1;
    localparam int S_W   = PJ_W + 1;
    localparam int B_W   = 2 * DIM_BITS;
    localparam int PK_W  = IW + 1 + B_W + 1;
    localparam int SUM_W = (PK_W + 1 > LW + 1) ? PK_W + 1 : LW + 1;

    logic signed [CW-1:0]        r_origin_x, r_origin_y, r_origin_z;
    logic        [VW-1:0]        r_vsize_x, r_vsize_y, r_vsize_z;
    logic        [3*DIM_BITS-1:0] r_dims;
    logic                        r_clamp;

    logic [DIM_BITS-1:0] dx, dy, dz;
    logic                en;
    logic [NSTG-1:0]     r_vld;

    ptlv_pkg::t_axis_res res_x, res_y, res_z;

    logic signed [IW-1:0] r_b_vi, r_b_vj, r_b_vk;
    logic signed [PJ_W-1:0] r_b_pj;
    logic        [B_W-1:0]  r_b_b;
    logic signed [IW:0]     r_b_km1;
    logic                   r_b_oor;

    logic signed [IW-1:0] r_c_vi, r_c_vj, r_c_vk;
    logic signed [S_W-1:0]  r_c_s;
    logic signed [PK_W-1:0] r_c_pk;
    logic                   r_c_oor;

    logic signed [IW:0]     vjm1;
    logic signed [SUM_W-1:0] sum;
    logic [LW-1:0]          n_lin;

    assign dx = r_dims[DIM_BITS-1:0];
    assign dy = r_dims[2*DIM_BITS-1:DIM_BITS];
    assign dz = r_dims[3*DIM_BITS-1:2*DIM_BITS];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= '0;
            r_origin_y <= '0;
            r_origin_z <= '0;
            r_vsize_x  <= VW'(1) << ptlv_pkg::COORD_FRAC_BITS;
            r_vsize_y  <= VW'(1) << ptlv_pkg::COORD_FRAC_BITS;
            r_vsize_z  <= VW'(1) << ptlv_pkg::COORD_FRAC_BITS;
            r_dims     <= {DIM_BITS'(1), DIM_BITS'(1), DIM_BITS'(1)};
            r_clamp    <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (ptlv_pkg::t_cfg_reg'(i_cfg_index))
                ptlv_pkg::CFG_ORIGIN_X:     r_origin_x <= i_cfg_data[CW-1:0];
                ptlv_pkg::CFG_ORIGIN_Y:     r_origin_y <= i_cfg_data[CW-1:0];
                ptlv_pkg::CFG_ORIGIN_Z:     r_origin_z <= i_cfg_data[CW-1:0];
                ptlv_pkg::CFG_VSIZE_X:      r_vsize_x  <= i_cfg_data[VW-1:0];
                ptlv_pkg::CFG_VSIZE_Y:      r_vsize_y  <= i_cfg_data[VW-1:0];
                ptlv_pkg::CFG_VSIZE_Z:      r_vsize_z  <= i_cfg_data[VW-1:0];
                ptlv_pkg::CFG_DIMS:         r_dims     <= i_cfg_data[3*DIM_BITS-1:0];
                ptlv_pkg::CFG_CLAMP_ENABLE: r_clamp    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // advance unless a finished result is held
    assign en          = !(r_vld[NSTG-1] && i_out_stall);
    assign o_in_stall  = !en;
    assign o_out_valid = r_vld[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTG-2:0], i_in_valid};
        end
    end

    ptlv_axis #(.DIM_BITS(DIM_BITS)) u_axis_x (
        .i_clk(i_clk), .i_en(en), .i_coord(i_in_data.coord_x), .i_origin(r_origin_x),
        .i_vsize(r_vsize_x), .i_dim(dx), .i_clamp(r_clamp), .o_res(res_x)
    );
    ptlv_axis #(.DIM_BITS(DIM_BITS)) u_axis_y (
        .i_clk(i_clk), .i_en(en), .i_coord(i_in_data.coord_y), .i_origin(r_origin_y),
        .i_vsize(r_vsize_y), .i_dim(dy), .i_clamp(r_clamp), .o_res(res_y)
    );
    ptlv_axis #(.DIM_BITS(DIM_BITS)) u_axis_z (
        .i_clk(i_clk), .i_en(en), .i_coord(i_in_data.coord_z), .i_origin(r_origin_z),
        .i_vsize(r_vsize_z), .i_dim(dz), .i_clamp(r_clamp), .o_res(res_z)
    );

    assign vjm1 = $signed({res_y.idx[IW-1], res_y.idx}) - $signed((IW+1)'(1));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_vi  <= res_x.idx;
            r_b_vj  <= res_y.idx;
            r_b_vk  <= res_z.idx;
            r_b_pj  <= vjm1 * $signed({1'b0, dx});
            r_b_b   <= B_W'(dx) * B_W'(dy);
            r_b_km1 <= $signed({res_z.idx[IW-1], res_z.idx}) - $signed((IW+1)'(1));
            r_b_oor <= res_x.oor || res_y.oor || res_z.oor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_vi  <= r_b_vi;
            r_c_vj  <= r_b_vj;
            r_c_vk  <= r_b_vk;
            r_c_s   <= S_W'(r_b_vi) + S_W'(r_b_pj);
            r_c_pk  <= r_b_km1 * $signed({1'b0, r_b_b});
            r_c_oor <= r_b_oor;
        end
    end

    assign sum = SUM_W'(r_c_s) + SUM_W'(r_c_pk);

    always_comb begin
        if (sum > $signed(SUM_W'({1'b0, {(LW-1){1'b1}}}))) begin
            n_lin = {1'b0, {(LW-1){1'b1}}};
        end else if (sum < -$signed(SUM_W'({1'b1, {(LW-1){1'b0}}}))) begin
            n_lin = {1'b1, {(LW-1){1'b0}}};
        end else begin
            n_lin = sum[LW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_out_data.voxel_i      <= r_c_vi;
            o_out_data.voxel_j      <= r_c_vj;
            o_out_data.voxel_k      <= r_c_vk;
            o_out_data.linear_index <= n_lin;
            o_out_data.out_of_range <= r_c_oor;
        end
    end

endmodule

/* src/ptlv_chk.sv */
// ----------------------------------------------------------------------------
// ptlv_chk
// Port-level checks for the voxel index block, bound to the top level.
// ----------------------------------------------------------------------------
module ptlv_chk (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               o_in_stall,
    input  logic               o_out_valid,
    input  logic               i_out_stall,
    input  ptlv_pkg::t_out_req o_out_data,
    input  logic               o_cfg_ready
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("held result changed");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("request stalled without a held result");

    a_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.out_of_range |->
            o_out_data.voxel_i >= 1 && o_out_data.voxel_j >= 1 && o_out_data.voxel_k >= 1)
        else $error("in-range result with index below one");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid |-> o_cfg_ready)
        else $error("config port not ready");

endmodule

bind physical_to_linear_voxel_index ptlv_chk u_ptlv_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data),
    .o_cfg_ready (o_cfg_ready)
);
